// File: rtl/core/tml_pkg.sv
// ----------------------------------------------------------------------------
// tml_pkg
// shared widths, stage counts, register indexes and helpers of the twist
// magnitude limiter
// ----------------------------------------------------------------------------
package tml_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_FIELDS = 6;
  localparam int DATA_W     = WORD_W * NUM_FIELDS;
  localparam int SQRT_STEPS = WORD_W;
  localparam int DIV_STEPS  = WORD_W;
  // entry, products, sum, root bits, quotient bits
  localparam int PAIR_DEPTH = 3 + SQRT_STEPS + DIV_STEPS;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic        [WORD_W-1:0] uword_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_LIN_X  = 3'd1,
    REG_LIN_Y  = 3'd2,
    REG_LIN_Z  = 3'd3,
    REG_ANG_X  = 3'd4,
    REG_ANG_Y  = 3'd5,
    REG_ANG_Z  = 3'd6
  } cfg_reg_t;

  // magnitude, -2^31 maps to 2^31
  function automatic uword_t mag(input word_t v);
    uword_t r;
    r = v[WORD_W-1] ? uword_t'(-v) : uword_t'(v);
    return r;
  endfunction

  function automatic word_t clamp_axis(input word_t v, input word_t lim);
    word_t r;
    r = v;
    if (lim > 0 && mag(v) > uword_t'(lim)) begin
      r = v[WORD_W-1] ? -lim : lim;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/tml_pair.sv
// ----------------------------------------------------------------------------
// tml_pair
// scales an xy pair onto its planar limit: squares, bit-serial root and
// bit-serial quotient, one bit per pipeline stage
// ----------------------------------------------------------------------------
module tml_pair (
  input  logic             clk,
  input  logic             en,
  input  tml_pkg::word_t   in_a,
  input  tml_pkg::word_t   in_b,
  input  tml_pkg::word_t   lim_x,
  input  tml_pkg::word_t   lim_y,
  input  logic             lim_on,
  output tml_pkg::word_t   out_a,
  output tml_pkg::word_t   out_b
);

  localparam int W  = tml_pkg::WORD_W;
  localparam int NS = tml_pkg::SQRT_STEPS;
  localparam int ND = tml_pkg::DIV_STEPS;

  typedef struct packed {
    tml_pkg::word_t     a;
    tml_pkg::word_t     b;
    logic [2*W-2:0]     pa;
    logic [2*W-2:0]     pb;
    logic               over;
  } side_t;

  // entry stage
  tml_pkg::word_t  a0, b0;
  tml_pkg::uword_t ua0, ub0;
  logic [W-2:0]    lim0;
  logic            act0;
  tml_pkg::word_t  lim_max;

  assign lim_max = (lim_x > lim_y) ? lim_x : lim_y;

  always_ff @(posedge clk) begin
    if (en) begin
      a0   <= in_a;
      b0   <= in_b;
      ua0  <= tml_pkg::mag(in_a);
      ub0  <= tml_pkg::mag(in_b);
      lim0 <= lim_max[W-2:0];
      act0 <= lim_on && (lim_max > 0);
    end
  end

  // products
  tml_pkg::word_t a1, b1;
  logic [2*W-1:0] sa1, sb1;
  logic [2*W-3:0] ll1;
  logic [2*W-2:0] pa1, pb1;
  logic           act1;

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a0;
      b1   <= b0;
      sa1  <= ua0 * ua0;
      sb1  <= ub0 * ub0;
      ll1  <= lim0 * lim0;
      pa1  <= ua0 * lim0;
      pb1  <= ub0 * lim0;
      act1 <= act0;
    end
  end

  // norm square and planar test
  logic [2*W-1:0] ssum;
  assign ssum = sa1 + sb1;

  side_t          sq_side [0:NS];
  logic [2*W-1:0] sq_s    [0:NS];
  logic [W+1:0]   sq_rem  [0:NS];
  tml_pkg::uword_t sq_root [0:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= '{a: a1, b: b1, pa: pa1, pb: pb1,
                      over: act1 && (ssum > {2'b00, ll1})};
      sq_s[0]    <= ssum;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // one root bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    logic [W+3:0] trial, test;
    assign trial = {sq_rem[i], sq_s[i][2*W-1-2*i -: 2]};
    assign test  = {2'b00, sq_root[i], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[i+1] <= sq_side[i];
        sq_s[i+1]    <= sq_s[i];
        if (trial >= test) begin
          sq_rem[i+1]  <= (W+2)'(trial - test);
          sq_root[i+1] <= {sq_root[i][W-2:0], 1'b1};
        end else begin
          sq_rem[i+1]  <= trial[W+1:0];
          sq_root[i+1] <= {sq_root[i][W-2:0], 1'b0};
        end
      end
    end
  end

  // one quotient bit per stage, both components share the norm
  side_t           dv_side [0:ND];
  tml_pkg::uword_t dv_n    [0:ND];
  tml_pkg::uword_t dv_ra   [0:ND];
  tml_pkg::uword_t dv_rb   [0:ND];
  tml_pkg::uword_t dv_qa   [0:ND];
  tml_pkg::uword_t dv_qb   [0:ND];

  assign dv_side[0] = sq_side[NS];
  assign dv_n[0]    = sq_root[NS];
  assign dv_ra[0]   = {1'b0, sq_side[NS].pa[2*W-2:W]};
  assign dv_rb[0]   = {1'b0, sq_side[NS].pb[2*W-2:W]};
  assign dv_qa[0]   = '0;
  assign dv_qb[0]   = '0;

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [W:0] ta, tb;
    assign ta = {dv_ra[j], dv_side[j].pa[W-1-j]};
    assign tb = {dv_rb[j], dv_side[j].pb[W-1-j]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[j+1] <= dv_side[j];
        dv_n[j+1]    <= dv_n[j];
        if (ta >= {1'b0, dv_n[j]}) begin
          dv_ra[j+1] <= W'(ta - {1'b0, dv_n[j]});
          dv_qa[j+1] <= {dv_qa[j][W-2:0], 1'b1};
        end else begin
          dv_ra[j+1] <= ta[W-1:0];
          dv_qa[j+1] <= {dv_qa[j][W-2:0], 1'b0};
        end
        if (tb >= {1'b0, dv_n[j]}) begin
          dv_rb[j+1] <= W'(tb - {1'b0, dv_n[j]});
          dv_qb[j+1] <= {dv_qb[j][W-2:0], 1'b1};
        end else begin
          dv_rb[j+1] <= tb[W-1:0];
          dv_qb[j+1] <= {dv_qb[j][W-2:0], 1'b0};
        end
      end
    end
  end

  // sign back on, truncation toward zero
  always_comb begin
    out_a = dv_side[ND].a;
    out_b = dv_side[ND].b;
    if (dv_side[ND].over) begin
      out_a = dv_side[ND].a[W-1] ? -tml_pkg::word_t'(dv_qa[ND])
                                 : tml_pkg::word_t'(dv_qa[ND]);
      out_b = dv_side[ND].b[W-1] ? -tml_pkg::word_t'(dv_qb[ND])
                                 : tml_pkg::word_t'(dv_qb[ND]);
    end
  end

endmodule

// File: rtl/core/twist_magnitude_limiter_top.sv
// ----------------------------------------------------------------------------
// twist_magnitude_limiter_top
// limits a six-component velocity command: planar xy norms and axial z
// ----------------------------------------------------------------------------
//   channel   dir  handshake          payload
//   s_axis    in   tvalid / tready    lin x,y,z, ang x,y,z
//   m_axis    out  tvalid / tready    limited lin x,y,z, ang x,y,z
//   cfg       in   cfg_we             cfg_index, cfg_data
//
// one item per cycle while the pipeline is not held; 3 entry/product/sum
// stages, 32 root stages and 32 quotient stages of the planar path
// the whole pipeline holds while the last stage is valid and m_axis_tready
// is low; s_axis_tready follows that enable
// rst clears valid bits and all limit registers
// ----------------------------------------------------------------------------
module twist_magnitude_limiter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // in_lin_x, in_lin_y, in_lin_z, in_ang_x, in_ang_y, in_ang_z
  input  logic [tml_pkg::DATA_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z
  output logic [tml_pkg::DATA_W-1:0]    m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [tml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tml_pkg::WORD_W-1:0]    cfg_data
);

  localparam int W = tml_pkg::WORD_W;
  localparam int D = tml_pkg::PAIR_DEPTH;

  logic           lim_on;
  tml_pkg::word_t lim_lin_x, lim_lin_y, lim_lin_z;
  tml_pkg::word_t lim_ang_x, lim_ang_y, lim_ang_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_on    <= 1'b0;
      lim_lin_x <= '0;
      lim_lin_y <= '0;
      lim_lin_z <= '0;
      lim_ang_x <= '0;
      lim_ang_y <= '0;
      lim_ang_z <= '0;
    end else if (cfg_we) begin
      case (tml_pkg::cfg_reg_t'(cfg_index))
        tml_pkg::REG_ENABLE: lim_on    <= cfg_data[0];
        tml_pkg::REG_LIN_X:  lim_lin_x <= cfg_data;
        tml_pkg::REG_LIN_Y:  lim_lin_y <= cfg_data;
        tml_pkg::REG_LIN_Z:  lim_lin_z <= cfg_data;
        tml_pkg::REG_ANG_X:  lim_ang_x <= cfg_data;
        tml_pkg::REG_ANG_Y:  lim_ang_y <= cfg_data;
        tml_pkg::REG_ANG_Z:  lim_ang_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic vld [0:D-1];

  assign en            = !vld[D-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < D; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < D; k++) vld[k] <= vld[k-1];
    end
  end

  tml_pkg::word_t in_lin_z, in_ang_z;
  assign in_lin_z = s_axis_tdata[3*W-1:2*W];
  assign in_ang_z = s_axis_tdata[6*W-1:5*W];

  // z components clamp at entry and ride a delay line
  tml_pkg::word_t lz [0:D-1];
  tml_pkg::word_t az [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      lz[0] <= lim_on ? tml_pkg::clamp_axis(in_lin_z, lim_lin_z) : in_lin_z;
      az[0] <= lim_on ? tml_pkg::clamp_axis(in_ang_z, lim_ang_z) : in_ang_z;
      for (int k = 1; k < D; k++) begin
        lz[k] <= lz[k-1];
        az[k] <= az[k-1];
      end
    end
  end

  tml_pkg::word_t out_lin_x, out_lin_y, out_ang_x, out_ang_y;

  tml_pair u_lin (
    .clk    (clk),
    .en     (en),
    .in_a   (s_axis_tdata[W-1:0]),
    .in_b   (s_axis_tdata[2*W-1:W]),
    .lim_x  (lim_lin_x),
    .lim_y  (lim_lin_y),
    .lim_on (lim_on),
    .out_a  (out_lin_x),
    .out_b  (out_lin_y)
  );

  tml_pair u_ang (
    .clk    (clk),
    .en     (en),
    .in_a   (s_axis_tdata[4*W-1:3*W]),
    .in_b   (s_axis_tdata[5*W-1:4*W]),
    .lim_x  (lim_ang_x),
    .lim_y  (lim_ang_y),
    .lim_on (lim_on),
    .out_a  (out_ang_x),
    .out_b  (out_ang_y)
  );

  assign m_axis_tdata = {az[D-1], out_ang_y, out_ang_x, lz[D-1], out_lin_y, out_lin_x};

  tml_pkg::word_t lin_plane;
  assign lin_plane = (lim_lin_x > lim_lin_y) ? lim_lin_x : lim_lin_y;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid item right after reset");

  a_lin_z_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && lim_on && lim_lin_z > 0
      |-> tml_pkg::mag(lz[D-1]) <= tml_pkg::uword_t'(lim_lin_z))
    else $error("linear z above its limit");

  a_ang_z_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && lim_on && lim_ang_z > 0
      |-> tml_pkg::mag(az[D-1]) <= tml_pkg::uword_t'(lim_ang_z))
    else $error("angular z above its limit");

  a_lin_plane: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && lim_on && lin_plane > 0
      |-> tml_pkg::mag(out_lin_x) <= tml_pkg::uword_t'(lin_plane)
       && tml_pkg::mag(out_lin_y) <= tml_pkg::uword_t'(lin_plane))
    else $error("linear xy component above planar limit");

endmodule
